### hw/rtl/ios_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ios_pkg
// Shared types and constants for the IPv4 option scanner.
// ----------------------------------------------------------------------------
package ios_pkg;

  localparam int NUM_KNOWN = 6;
  localparam logic [5:0] HEADER_BASE = 6'd20;

  localparam logic [7:0] OPT_EOL  = 8'd0;
  localparam logic [7:0] OPT_RR   = 8'd7;
  localparam logic [7:0] OPT_TS   = 8'd68;
  localparam logic [7:0] OPT_SEC  = 8'd130;
  localparam logic [7:0] OPT_LSRR = 8'd131;
  localparam logic [7:0] OPT_SSRR = 8'd137;
  localparam logic [7:0] OPT_SID  = 8'd136;

  localparam logic [2:0] IDX_RR   = 3'd0;
  localparam logic [2:0] IDX_TS   = 3'd1;
  localparam logic [2:0] IDX_SEC  = 3'd2;
  localparam logic [2:0] IDX_LSRR = 3'd3;
  localparam logic [2:0] IDX_SSRR = 3'd4;
  localparam logic [2:0] IDX_SID  = 3'd5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_BOTH = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } known_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] error_offset;
    logic [5:0] present_mask;
    logic [5:0] rr_offset;
    logic [5:0] ts_offset;
    logic [5:0] sec_offset;
    logic [5:0] lsrr_offset;
    logic [5:0] ssrr_offset;
    logic [5:0] sid_offset;
  } scan_result_t;

  function automatic known_t known_lookup(input logic [7:0] t);
    known_t r;
    r.hit = 1'b1;
    r.idx = IDX_RR;
    case (t)
      OPT_RR:   r.idx = IDX_RR;
      OPT_TS:   r.idx = IDX_TS;
      OPT_SEC:  r.idx = IDX_SEC;
      OPT_LSRR: r.idx = IDX_LSRR;
      OPT_SSRR: r.idx = IDX_SSRR;
      OPT_SID:  r.idx = IDX_SID;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ipv4_option_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_option_scanner
// Walks the IPv4 options area of one header and reports option offsets
// and header status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one option byte per request,
//   in header order, with last set on the final byte of the header.
//   Output channel (out_valid/out_ready) carries one summary per header:
//   status, error pointer, presence mask and the six option offsets.
//   Throughput: one byte per cycle while no summary is stalled; a last byte
//   waits in the byte register until the result register can take its summary.
//   The last byte is held in the byte register; the summary is loaded into
//   the result register when that byte advances, which sets out_valid.
//   Reset clears the scan state and both valid flags; the next byte starts a
//   new header. After each summary the scan state returns to reset.
//   If the receiver stalls, the held summary stays put; bytes of the next
//   header keep flowing until its last byte needs the result register.
// ----------------------------------------------------------------------------
module ipv4_option_scanner #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] opt_byte,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [5:0]      error_offset,
  output logic [5:0]      present_mask,
  output logic [5:0]      rr_offset,
  output logic [5:0]      ts_offset,
  output logic [5:0]      sec_offset,
  output logic [5:0]      lsrr_offset,
  output logic [5:0]      ssrr_offset,
  output logic [5:0]      sid_offset
);
  import ios_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         s1_adv;
  scan_result_t scan_res;
  scan_result_t res;

  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  ios_scan #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .opt_byte(s1_byte),
    .last    (s1_last),
    .result  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= opt_byte;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      res <= scan_res;
    end
  end

  assign status       = res.status;
  assign error_offset = res.error_offset;
  assign present_mask = res.present_mask;
  assign rr_offset    = res.rr_offset;
  assign ts_offset    = res.ts_offset;
  assign sec_offset   = res.sec_offset;
  assign lsrr_offset  = res.lsrr_offset;
  assign ssrr_offset  = res.ssrr_offset;
  assign sid_offset   = res.sid_offset;

  a_ok_no_pointer: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> error_offset == 6'd0)
    else $error("ok status with nonzero error pointer");

  a_both_routes: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BOTH |->
      present_mask[IDX_LSRR] && present_mask[IDX_SSRR] && error_offset == lsrr_offset)
    else $error("source route status inconsistent with mask");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !present_mask[IDX_RR] |-> rr_offset == 6'd0)
    else $error("absent record route has an offset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

### hw/rtl/ios_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ios_scan
// Option list walker: per-byte state update and end-of-header summary.
// ----------------------------------------------------------------------------
module ios_scan #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          opt_byte,
  input  wire logic                last,
  output ios_pkg::scan_result_t    result
);
  import ios_pkg::*;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_SKIP, PH_DONE} phase_t;

  localparam logic [5:0] MAX_POS = 6'(MAX_OPTION_BYTES);

  phase_t     phase, phase_next;
  logic [7:0] skip, skip_next;
  logic [5:0] pos, pos_next;
  logic [5:0] flags, flags_next;
  logic [5:0] offs [NUM_KNOWN];
  logic [5:0] offs_next [NUM_KNOWN];
  logic       dup, dup_next;
  logic [5:0] pend, pend_next;
  known_t     kn;

  always_comb begin
    phase_next = phase;
    skip_next  = skip;
    pos_next   = pos;
    flags_next = flags;
    offs_next  = offs;
    dup_next   = dup;
    pend_next  = pend;
    kn         = known_lookup(opt_byte);
    if (pos < MAX_POS) begin
      pos_next = pos + 6'd1;
      case (phase)
        PH_TYPE: begin
          if (opt_byte == OPT_EOL) begin
            phase_next = PH_DONE;
          end else if (kn.hit) begin
            if (flags[kn.idx]) begin
              dup_next  = 1'b1;
              pend_next = offs[kn.idx];
            end else begin
              flags_next[kn.idx] = 1'b1;
              offs_next[kn.idx]  = HEADER_BASE + pos;
            end
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (opt_byte == 8'd0) begin
            phase_next = PH_DONE;
          end else if (opt_byte <= 8'd2) begin
            phase_next = PH_TYPE;
          end else begin
            skip_next  = opt_byte - 8'd2;
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_next = skip - 8'd1;
          if (skip == 8'd1) begin
            phase_next = PH_TYPE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.status       = STATUS_OK;
    result.error_offset = 6'd0;
    if (dup_next) begin
      result.status       = STATUS_DUP;
      result.error_offset = pend_next;
    end else if (flags_next[IDX_LSRR] && flags_next[IDX_SSRR]) begin
      result.status       = STATUS_BOTH;
      result.error_offset = offs_next[IDX_LSRR];
    end
    result.present_mask = flags_next;
    result.rr_offset    = offs_next[IDX_RR];
    result.ts_offset    = offs_next[IDX_TS];
    result.sec_offset   = offs_next[IDX_SEC];
    result.lsrr_offset  = offs_next[IDX_LSRR];
    result.ssrr_offset  = offs_next[IDX_SSRR];
    result.sid_offset   = offs_next[IDX_SID];
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= PH_TYPE;
      skip  <= 8'd0;
      pos   <= 6'd0;
      flags <= 6'd0;
      dup   <= 1'b0;
      pend  <= 6'd0;
      for (int i = 0; i < NUM_KNOWN; i++) begin
        offs[i] <= 6'd0;
      end
    end else if (step) begin
      phase <= phase_next;
      skip  <= skip_next;
      pos   <= pos_next;
      flags <= flags_next;
      dup   <= dup_next;
      pend  <= pend_next;
      offs  <= offs_next;
    end
  end

endmodule
`default_nettype wire
